// ===== rtl/pmst_pkg.sv =====
// shared types and constants for the prim spanning tree block
package pmst_pkg;

  // field widths of the beats
  localparam int unsigned OP_W   = 1;
  localparam int unsigned VTX_W  = 5;
  localparam int unsigned WGT_W  = 17;

  // weight that marks a missing edge
  localparam logic [WGT_W-1:0] NO_EDGE = 17'd100000;

  // input op codes
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_START = 1'b1;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned NC_W   = 6;
  localparam logic [NC_W-1:0] NC_RESET = 6'd2;
  // register index bit of the word address
  localparam logic CFG_IDX_NODE_COUNT = 1'b0;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR2,
    ST_SWEEP,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/pmst_if.sv =====
// valid/ready channels for matrix/start beats and tree edge beats
interface pmst_in_if;
  logic                             valid;
  logic                             ready;
  logic [pmst_pkg::OP_W-1:0]        op;
  logic [pmst_pkg::VTX_W-1:0]       row;
  logic [pmst_pkg::VTX_W-1:0]       col;
  logic [pmst_pkg::WGT_W-1:0]       weight;

  modport source (output valid, op, row, col, weight, input ready);
  modport sink   (input valid, op, row, col, weight, output ready);
endinterface

interface pmst_out_if;
  logic                             valid;
  logic                             ready;
  logic [pmst_pkg::VTX_W-1:0]       parent_vertex;
  logic [pmst_pkg::VTX_W-1:0]       child_vertex;
  logic                             last;

  modport source (output valid, parent_vertex, child_vertex, last, input ready);
  modport sink   (input valid, parent_vertex, child_vertex, last, output ready);
endinterface

// ===== rtl/pmst_wmem.sv =====
// weight matrix store, one write and one registered read per cycle
module pmst_wmem #(
  parameter int unsigned AW = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [pmst_pkg::WGT_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [pmst_pkg::WGT_W-1:0] rdata
);

  logic [pmst_pkg::WGT_W-1:0] mem [2**AW];
  logic [pmst_pkg::WGT_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pmst_cell.sv =====
// one vertex cell: holds best cost and parent, relaxes and passes the min token on
module pmst_cell #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned IDX       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(MAX_NODES+1)-1:0]       n,
  input  logic                                 init,
  input  logic [$clog2(MAX_NODES)-1:0]         pick,
  input  logic [pmst_pkg::WGT_W-1:0]           w,
  input  logic                                 ti_valid,
  input  logic [pmst_pkg::WGT_W-1:0]           ti_cost,
  input  logic [$clog2(MAX_NODES)-1:0]         ti_vtx,
  input  logic [$clog2(MAX_NODES)-1:0]         ti_par,
  output logic                                 to_valid,
  output logic [pmst_pkg::WGT_W-1:0]           to_cost,
  output logic [$clog2(MAX_NODES)-1:0]         to_vtx,
  output logic [$clog2(MAX_NODES)-1:0]         to_par
);

  localparam int unsigned VW = $clog2(MAX_NODES);
  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam logic [VW-1:0] IDX_V = VW'(IDX);
  localparam logic [NW-1:0] IDX_N = NW'(IDX);

  logic [pmst_pkg::WGT_W-1:0] cost_r, cost_nxt;
  logic [VW-1:0]              par_r, par_nxt;
  logic                       to_valid_r;
  logic [pmst_pkg::WGT_W-1:0] to_cost_r, to_cost_nxt;
  logic [VW-1:0]              to_vtx_r, to_vtx_nxt;
  logic [VW-1:0]              to_par_r, to_par_nxt;

  logic                       active;
  logic [pmst_pkg::WGT_W-1:0] cur;
  logic [pmst_pkg::WGT_W-1:0] cand_cost;
  logic [VW-1:0]              cand_par;
  logic                       take;

  // relax against the new tree vertex, then compete for the running minimum
  always_comb begin
    active = (IDX != 0) && (IDX_N < n);
    cur    = (pick == IDX_V) ? '0 : cost_r;
    if (init) begin
      cand_cost = w;
      cand_par  = '0;
    end else if ((cur != '0) && (w < cur)) begin
      cand_cost = w;
      cand_par  = pick;
    end else begin
      cand_cost = cur;
      cand_par  = par_r;
    end
    take = active && (cand_cost != '0) && (cand_cost < ti_cost);

    to_cost_nxt = take ? cand_cost : ti_cost;
    to_vtx_nxt  = take ? IDX_V     : ti_vtx;
    to_par_nxt  = take ? cand_par  : ti_par;

    cost_nxt = (ti_valid && active) ? cand_cost : cost_r;
    par_nxt  = (ti_valid && active) ? cand_par  : par_r;
  end

  // token valid to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_valid_r <= 1'b0;
    end else begin
      to_valid_r <= ti_valid;
    end
  end

  // vertex state and token payload
  always_ff @(posedge clk) begin
    cost_r <= cost_nxt;
    par_r  <= par_nxt;
    if (ti_valid) begin
      to_cost_r <= to_cost_nxt;
      to_vtx_r  <= to_vtx_nxt;
      to_par_r  <= to_par_nxt;
    end
  end

  assign to_valid = to_valid_r;
  assign to_cost  = to_cost_r;
  assign to_vtx   = to_vtx_r;
  assign to_par   = to_par_r;

endmodule

// ===== rtl/prim_mst_matrix_unit.sv =====
// prim minimum spanning tree over a stored adjacency matrix, top level
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    op, row, col, weight
//   out_ch    out  valid/ready    parent_vertex, child_vertex, last
//   cfg_*     in   apb write/read node_count at word 0
//
// a matrix write beat writes both mirrored memory entries, row/col then col/row.
// a start beat runs node_count-1 sweeps; each sweep walks a min token down
// the row of MAX_NODES cells, fed one matrix word per cycle from the single
// read port.
// in_ch is taken only when no write or run is in flight; a stalled out_ch
// holds the next sweep until the edge register frees up.
// rst_n is synchronous; the matrix holds no reset value.
module prim_mst_matrix_unit #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pmst_in_if.sink                       in_ch,
  pmst_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pmst_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [pmst_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [pmst_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int unsigned VW = $clog2(MAX_NODES);
  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = 2 * VW;
  localparam logic [VW-1:0] LAST_V = VW'(MAX_NODES - 1);
  localparam logic [NW-1:0] MAX_N  = NW'(MAX_NODES);
  localparam int unsigned WW = pmst_pkg::WGT_W;

  pmst_pkg::state_t state_r, state_nxt;

  logic [pmst_pkg::NC_W-1:0] node_count_r;
  logic [NW-1:0]             nc_sat;

  logic [VW-1:0]  cnt_r, cnt_nxt;
  logic [NW-1:0]  step_r, step_nxt;
  logic [VW-1:0]  pick_r, pick_nxt;
  logic           init_r, init_nxt;
  logic           tok0_valid_r;

  logic [VW-1:0]  wr_row_r, wr_col_r;
  logic [WW-1:0]  wr_w_r;
  logic           wr_ok_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [pmst_pkg::VTX_W-1:0] out_par_r, out_child_r;
  logic                       out_last_r;

  logic           in_fire;
  logic           in_ok;
  logic           out_free;
  logic           is_last;
  logic           load_out;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [WW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [WW-1:0]  mem_rdata;

  logic           tv [MAX_NODES+1];
  logic [WW-1:0]  tc [MAX_NODES+1];
  logic [VW-1:0]  tx [MAX_NODES+1];
  logic [VW-1:0]  tp [MAX_NODES+1];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= pmst_pkg::NC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == pmst_pkg::CFG_IDX_NODE_COUNT)) begin
      node_count_r <= cfg_pwdata[pmst_pkg::NC_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == pmst_pkg::CFG_IDX_NODE_COUNT) ?
                      pmst_pkg::CFG_DW'(node_count_r) : '0;

  // vertex count clipped to the cell row
  assign nc_sat = (32'(node_count_r) > MAX_NODES) ? MAX_N : NW'(node_count_r);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ok    = (32'(in_ch.row) < MAX_NODES) && (32'(in_ch.col) < MAX_NODES);
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = (step_r == NW'(nc_sat - NW'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmst_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == pmst_pkg::OP_WRITE) begin
            state_nxt = pmst_pkg::ST_WR2;
          end else if (nc_sat >= NW'(2)) begin
            state_nxt = pmst_pkg::ST_SWEEP;
          end
        end
      end
      pmst_pkg::ST_WR2: begin
        state_nxt = pmst_pkg::ST_IDLE;
      end
      pmst_pkg::ST_SWEEP: begin
        if (tv[MAX_NODES]) begin
          state_nxt = pmst_pkg::ST_EMIT;
        end
      end
      pmst_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = is_last ? pmst_pkg::ST_IDLE : pmst_pkg::ST_SWEEP;
        end
      end
      default: state_nxt = pmst_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and counters
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = {VW'(in_ch.row), VW'(in_ch.col)};
    mem_wdata   = in_ch.weight;
    mem_raddr   = {pick_r, cnt_r};
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    pick_nxt    = pick_r;
    init_nxt    = init_r;
    load_out    = 1'b0;
    unique case (state_r)
      pmst_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire && (in_ch.op == pmst_pkg::OP_WRITE)) begin
          mem_we = in_ok;
        end
        cnt_nxt  = '0;
        step_nxt = NW'(1);
        pick_nxt = '0;
        init_nxt = 1'b1;
      end
      pmst_pkg::ST_WR2: begin
        mem_we    = wr_ok_r;
        mem_waddr = {wr_col_r, wr_row_r};
        mem_wdata = wr_w_r;
      end
      pmst_pkg::ST_SWEEP: begin
        if (cnt_r != LAST_V) begin
          cnt_nxt = cnt_r + VW'(1);
        end
      end
      pmst_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          cnt_nxt  = '0;
          step_nxt = step_r + NW'(1);
          pick_nxt = tx[MAX_NODES];
          init_nxt = 1'b0;
        end
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pmst_pkg::ST_IDLE;
      tok0_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tok0_valid_r <= (state_r == pmst_pkg::ST_SWEEP) && (cnt_r == '0);
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // sweep bookkeeping and write holding registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
    pick_r <= pick_nxt;
    init_r <= init_nxt;
    if (in_fire) begin
      wr_row_r <= VW'(in_ch.row);
      wr_col_r <= VW'(in_ch.col);
      wr_w_r   <= in_ch.weight;
      wr_ok_r  <= in_ok;
    end
  end

  // edge output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_par_r   <= pmst_pkg::VTX_W'(tp[MAX_NODES]);
      out_child_r <= pmst_pkg::VTX_W'(tx[MAX_NODES]);
      out_last_r  <= is_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.parent_vertex = out_par_r;
  assign out_ch.child_vertex  = out_child_r;
  assign out_ch.last          = out_last_r;

  // weight matrix
  pmst_wmem #(
    .AW (AW)
  ) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // fresh min token enters the first cell
  assign tv[0] = tok0_valid_r;
  assign tc[0] = pmst_pkg::NO_EDGE;
  assign tx[0] = '0;
  assign tp[0] = '0;

  // row of vertex cells
  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    pmst_cell #(
      .MAX_NODES (MAX_NODES),
      .IDX       (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .n        (nc_sat),
      .init     (init_r),
      .pick     (pick_r),
      .w        (mem_rdata),
      .ti_valid (tv[g]),
      .ti_cost  (tc[g]),
      .ti_vtx   (tx[g]),
      .ti_par   (tp[g]),
      .to_valid (tv[g+1]),
      .to_cost  (tc[g+1]),
      .to_vtx   (tx[g+1]),
      .to_par   (tp[g+1])
    );
  end

endmodule

// ===== tb/pmst_checker.sv =====
// edge scoreboard for the prim spanning tree block: mirrors matrix and node count, predicts edges
module pmst_checker #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pmst_in_if                            in_ch,
  pmst_out_if                           out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [pmst_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [pmst_pkg::CFG_DW-1:0]   cfg_pwdata,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pmst_pkg::VTX_W-1:0] parent_vertex;
    logic [pmst_pkg::VTX_W-1:0] child_vertex;
    logic                       last;
  } tree_edge_t;

  // mirrored matrix and per-run tree bookkeeping
  logic [pmst_pkg::WGT_W-1:0] edge_w    [MAX_NODES*MAX_NODES];
  logic [pmst_pkg::WGT_W-1:0] tree_cost [MAX_NODES];
  logic [pmst_pkg::VTX_W-1:0] tree_from [MAX_NODES];
  logic [pmst_pkg::NC_W-1:0]  node_cnt;
  tree_edge_t                 edge_queue[$];
  int                         mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
    node_cnt   = pmst_pkg::NC_RESET;
  end

  // prim from vertex 0; a cost of zero means the vertex already joined the tree
  function automatic void grow_tree();
    int unsigned                n;
    int unsigned                pick;
    logic [pmst_pkg::WGT_W-1:0] lowest;
    logic [pmst_pkg::WGT_W-1:0] w;
    tree_edge_t                 e;
    n = (node_cnt > MAX_NODES) ? MAX_NODES : int'(node_cnt);
    if (n < 2) return;
    tree_cost[0] = '0;
    tree_from[0] = '0;
    for (int unsigned v = 1; v < n; v++) begin
      tree_cost[v] = edge_w[v];
      tree_from[v] = '0;
    end
    for (int unsigned step = 1; step < n; step++) begin
      lowest = pmst_pkg::NO_EDGE;
      pick   = 0;
      // strictly lower cost wins, so ties go to the lowest vertex
      for (int unsigned v = 1; v < n; v++) begin
        if (tree_cost[v] != '0 && tree_cost[v] < lowest) begin
          lowest = tree_cost[v];
          pick   = v;
        end
      end
      // nothing reachable falls back to vertex 0
      e.parent_vertex = tree_from[pick];
      e.child_vertex  = pmst_pkg::VTX_W'(pick);
      e.last          = (step == n - 1);
      edge_queue.push_back(e);
      tree_cost[pick] = '0;
      for (int unsigned v = 1; v < n; v++) begin
        w = edge_w[pick*MAX_NODES + v];
        if (tree_cost[v] != '0 && w < tree_cost[v]) begin
          tree_cost[v] = w;
          tree_from[v] = pmst_pkg::VTX_W'(pick);
        end
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    tree_edge_t seen;
    tree_edge_t want;
    if (!rst_n) begin
      node_cnt = pmst_pkg::NC_RESET;
      edge_queue.delete();
    end else begin
      // edge beat against the oldest expected edge
      if (out_ch.valid && out_ch.ready) begin
        seen.parent_vertex = out_ch.parent_vertex;
        seen.child_vertex  = out_ch.child_vertex;
        seen.last          = out_ch.last;
        if (edge_queue.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected edge beat: parent %0d child %0d last %0b",
                     seen.parent_vertex, seen.child_vertex, seen.last);
        end else begin
          want = edge_queue.pop_front();
          if (seen.parent_vertex !== want.parent_vertex ||
              seen.child_vertex  !== want.child_vertex  ||
              seen.last          !== want.last) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
              $display("edge mismatch: expected %0d->%0d last %0b, got %0d->%0d last %0b",
                       want.parent_vertex, want.child_vertex, want.last,
                       seen.parent_vertex, seen.child_vertex, seen.last);
          end
        end
      end
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == pmst_pkg::CFG_IDX_NODE_COUNT)
        node_cnt = cfg_pwdata[pmst_pkg::NC_W-1:0];
      // matrix write or run start
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == pmst_pkg::OP_WRITE) begin
          if (in_ch.row < MAX_NODES && in_ch.col < MAX_NODES) begin
            edge_w[in_ch.row*MAX_NODES + in_ch.col] = in_ch.weight;
            edge_w[in_ch.col*MAX_NODES + in_ch.row] = in_ch.weight;
          end
        end else begin
          grow_tree();
        end
      end
    end
    pending = edge_queue.size();
  end

endmodule

// ===== tb/tb_prim_mst_matrix_unit.sv =====
// top of the prim spanning tree testbench: clock, reset, stimulus, register writes, verdict
module tb_prim_mst_matrix_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_NODES    = 32;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned SETTLE       = 150;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned TOTAL_BEATS  = 430;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned SMALL_N      = 8;
  localparam int unsigned REACH_N      = 4;
  localparam logic [pmst_pkg::CFG_AW-1:0] NODE_COUNT_ADDR =
    {pmst_pkg::CFG_IDX_NODE_COUNT, 2'b00};

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [pmst_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [pmst_pkg::CFG_DW-1:0]   cfg_pwdata;
  logic [pmst_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  pmst_in_if  in_ch ();
  pmst_out_if out_ch ();

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned sent_beats = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          written [MAX_NODES][MAX_NODES];
  logic [pmst_pkg::WGT_W-1:0] mirror_w [MAX_NODES][MAX_NODES];
  logic [pmst_pkg::NC_W-1:0]  node_sel = pmst_pkg::NC_RESET;

  prim_mst_matrix_unit #(.MAX_NODES(MAX_NODES)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pmst_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // edge receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // mostly small weights so ties are common, plus zero, no-edge and over-range values
  function automatic logic [pmst_pkg::WGT_W-1:0] rand_weight();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 55) return pmst_pkg::WGT_W'($urandom_range(1, 40));
    if (kind < 65) return '0;
    if (kind < 75) return pmst_pkg::NO_EDGE;
    if (kind < 82) return pmst_pkg::WGT_W'($urandom_range(100001, 131071));
    return pmst_pkg::WGT_W'($urandom_range(0, 131071));
  endfunction

  // weights that keep a vertex out of reach: no edge, at or over the mark, or zero
  function automatic logic [pmst_pkg::WGT_W-1:0] cut_weight();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 50) return pmst_pkg::NO_EDGE;
    if (kind < 80) return pmst_pkg::WGT_W'($urandom_range(100000, 131071));
    return '0;
  endfunction

  // one input beat; returns at the falling edge after it was taken, valid still high
  task automatic send_beat(input logic [pmst_pkg::OP_W-1:0] op,
                           input logic [pmst_pkg::VTX_W-1:0] r,
                           input logic [pmst_pkg::VTX_W-1:0] c,
                           input logic [pmst_pkg::WGT_W-1:0] w);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.row    <= r;
    in_ch.col    <= c;
    in_ch.weight <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (op == pmst_pkg::OP_WRITE) begin
      written[r][c]  = 1'b1;
      written[c][r]  = 1'b1;
      mirror_w[r][c] = w;
      mirror_w[c][r] = w;
    end
    sent_beats++;
    @(negedge clk);
  endtask

  // make every entry a run reads valid; above SMALL_N only the first REACH_N
  // vertices can join, so their links to the other vertices stay out of reach
  task automatic fill_matrix(input int unsigned n);
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = r; c < n; c++)
        if (n <= SMALL_N || c < REACH_N) begin
          if (!written[r][c])
            send_beat(pmst_pkg::OP_WRITE, pmst_pkg::VTX_W'(r), pmst_pkg::VTX_W'(c),
                      (r == c) ? '0 : rand_weight());
        end else if (r < REACH_N) begin
          if (!written[r][c] ||
              (mirror_w[r][c] != '0 && mirror_w[r][c] < pmst_pkg::NO_EDGE))
            send_beat(pmst_pkg::OP_WRITE, pmst_pkg::VTX_W'(r), pmst_pkg::VTX_W'(c),
                      cut_weight());
        end
  endtask

  // fill the matrix for the current node count, then a start beat with random don't-care fields
  task automatic run_tree();
    int unsigned n;
    n = (node_sel > MAX_NODES) ? MAX_NODES : int'(node_sel);
    if (n >= 2) fill_matrix(n);
    send_beat(pmst_pkg::OP_START, pmst_pkg::VTX_W'($urandom), pmst_pkg::VTX_W'($urandom),
              pmst_pkg::WGT_W'($urandom));
  endtask

  // drop valid, wait for every expected edge, then let the last sweep finish
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // apb write of node_count while the block is idle
  task automatic set_node_count(input logic [pmst_pkg::NC_W-1:0] value);
    quiesce();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= NODE_COUNT_ADDR;
    cfg_pwdata  <= pmst_pkg::CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    node_sel = value;
  endtask

  initial begin
    int unsigned               phase;
    int unsigned               n_eff;
    int unsigned               runs;
    logic [pmst_pkg::NC_W-1:0] nc;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = pmst_pkg::OP_WRITE;
    in_ch.row    = '0;
    in_ch.col    = '0;
    in_ch.weight = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, two vertices from reset
    send_beat(pmst_pkg::OP_WRITE, 5'd0, 5'd0, '0);
    send_beat(pmst_pkg::OP_WRITE, 5'd1, 5'd1, '0);
    send_beat(pmst_pkg::OP_WRITE, 5'd0, 5'd1, 17'd5);
    send_beat(pmst_pkg::OP_START, '0, '0, '0);
    // no edge left: falls back to vertex 0
    send_beat(pmst_pkg::OP_WRITE, 5'd1, 5'd0, pmst_pkg::NO_EDGE);
    send_beat(pmst_pkg::OP_START, '0, '0, '0);
    // zero off-diagonal weight looks already joined
    send_beat(pmst_pkg::OP_WRITE, 5'd0, 5'd1, '0);
    send_beat(pmst_pkg::OP_START, '0, '0, '0);
    // weight above the no-edge mark is never chosen
    send_beat(pmst_pkg::OP_WRITE, 5'd1, 5'd0, '1);
    send_beat(pmst_pkg::OP_START, '0, '0, '0);
    // just under the no-edge mark, start fields all ones
    send_beat(pmst_pkg::OP_WRITE, 5'd0, 5'd1, 17'd99999);
    send_beat(pmst_pkg::OP_START, '1, '1, '1);
    // far corners of the matrix
    send_beat(pmst_pkg::OP_WRITE, 5'd31, 5'd0, '0);
    send_beat(pmst_pkg::OP_WRITE, 5'd0, 5'd31, '1);
    send_beat(pmst_pkg::OP_WRITE, 5'd31, 5'd31, 17'h0aaaa);
    send_beat(pmst_pkg::OP_WRITE, 5'd0, 5'd1, 17'd1);
    send_beat(pmst_pkg::OP_START, '0, '0, '0);

    // random phases: a node count, then writes and runs within it
    phase = 0;
    while (sent_beats < TOTAL_BEATS) begin
      idle_on = !(phase >= 6 && phase < 12);
      case (phase)
        0: nc = 6'd0;
        1: nc = 6'd32;
        2: nc = 6'd1;
        3: nc = 6'd63;
        4: nc = 6'd2;
        default: begin
          runs = $urandom_range(99);
          if (runs < 70)      nc = pmst_pkg::NC_W'($urandom_range(2, 8));
          else if (runs < 90) nc = pmst_pkg::NC_W'($urandom_range(9, 31));
          else if (runs < 95) nc = 6'd32;
          else if (runs < 97) nc = pmst_pkg::NC_W'($urandom_range(0, 1));
          else                nc = pmst_pkg::NC_W'($urandom_range(33, 63));
        end
      endcase
      set_node_count(nc);
      n_eff = (nc > MAX_NODES) ? MAX_NODES : int'(nc);
      // long receiver hold-off with two back-to-back full runs queued
      if (phase == 1) begin
        fill_matrix(n_eff);
        hold_req = 1'b1;
      end
      runs = (phase == 1) ? 2 : $urandom_range(1, 3);
      repeat (runs) begin
        repeat ($urandom_range(0, 10)) begin
          if (n_eff >= 2 && $urandom_range(99) < 80)
            send_beat(pmst_pkg::OP_WRITE, pmst_pkg::VTX_W'($urandom_range(n_eff - 1)),
                      pmst_pkg::VTX_W'($urandom_range(n_eff - 1)), rand_weight());
          else
            send_beat(pmst_pkg::OP_WRITE, pmst_pkg::VTX_W'($urandom),
                      pmst_pkg::VTX_W'($urandom), rand_weight());
        end
        run_tree();
      end
      phase++;
    end

    // drain and verdict
    quiesce();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pmst_pkg.sv
rtl/pmst_if.sv
rtl/pmst_wmem.sv
rtl/pmst_cell.sv
rtl/prim_mst_matrix_unit.sv
tb/pmst_checker.sv
tb/tb_prim_mst_matrix_unit.sv
